[src/gcf_pkg.sv]
package gcf_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int PIX_W      = 16;
    localparam int EDGE_W     = PIX_W + 1;
    localparam int POS_W      = 9;
    localparam int CFG_W      = 10;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int OUT_DATA_W = ((EDGE_W + 2 * POS_W + 7) / 8) * 8;

    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // result kinds pending for one pixel, lowest bit goes out first
    localparam int RES_UP     = 0;
    localparam int RES_LEFT   = 1;
    localparam int RES_CORNER = 2;
    localparam int RES_N      = 3;

    typedef logic [PIX_W-1:0] t_pixel;
    typedef logic [POS_W-1:0] t_pos;
    typedef logic [CFG_W-1:0] t_dim;

    function automatic t_pixel abs_diff(input t_pixel a, input t_pixel b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

[src/gcf_ram.sv]
module gcf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[src/gradient_contour_filter_unit.sv]
// Forward-difference edge filter for a raster pixel stream. One pixel word is
// taken per clock while the output is not stalled; each pixel above the bottom
// row yields one result, issued when the pixel below it arrives. Bottom-row
// pixels yield two results (the pixel above and the pixel to the left; the
// first column only the one above) and the bottom-right pixel three, so on
// the last row the input waits for the single output register, which issues
// one result per clock when not stalled. A result passes the pixel stage
// registers, then the output register. The previous row sits in a 512 x 16
// line RAM with one write and two reads per clock; it needs no clearing after
// reset. Width and height may only be written while the block is idle.
module gradient_contour_filter_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [gcf_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [gcf_pkg::PIX_W-1:0]           s_axis_tdata,  // pixel_value
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [gcf_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // edge_value, out_row, out_col
    output logic                                m_axis_tlast,  // last_of_run
    output logic                                m_axis_tuser   // image_done
);

    localparam gcf_pkg::t_dim MAX_W = gcf_pkg::CFG_W'(gcf_pkg::MAX_WIDTH);
    localparam gcf_pkg::t_dim MAX_H = gcf_pkg::CFG_W'(gcf_pkg::MAX_HEIGHT);

    gcf_pkg::t_dim   r_width;
    gcf_pkg::t_dim   r_height;
    gcf_pkg::t_pos   r_row;
    gcf_pkg::t_pos   r_col;
    gcf_pkg::t_pixel r_left;

    gcf_pkg::t_dim w_eff;
    gcf_pkg::t_dim h_eff;
    gcf_pkg::t_dim row_tmp;
    gcf_pkg::t_dim row_cur;
    gcf_pkg::t_dim col_cur;
    gcf_pkg::t_dim row_nxt;
    gcf_pkg::t_dim col_nxt;
    logic [gcf_pkg::RES_N-1:0] new_mask;
    logic                      new_right;

    logic [gcf_pkg::RES_N-1:0] r_mask;
    logic [gcf_pkg::RES_N-1:0] mask_rest;
    logic                      r_s1_right;
    gcf_pkg::t_pixel           r_s1_pix;
    gcf_pkg::t_pixel           r_s1_left;
    gcf_pkg::t_pos             r_s1_row;
    gcf_pkg::t_pos             r_s1_col;
    gcf_pkg::t_pixel           above;
    gcf_pkg::t_pixel           above_right;

    logic [gcf_pkg::EDGE_W-1:0] sel_edge;
    gcf_pkg::t_pos              sel_row;
    gcf_pkg::t_pos              sel_col;
    logic                       sel_done;

    logic r_out_valid;
    logic [gcf_pkg::EDGE_W-1:0] r_out_edge;
    gcf_pkg::t_pos              r_out_row;
    gcf_pkg::t_pos              r_out_col;
    logic                       r_out_last;
    logic                       r_out_done;

    logic accept;
    logic out_load;
    logic emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= MAX_W;
            r_height <= MAX_H;
        end else if (i_cfg_we) begin
            if (i_cfg_index == gcf_pkg::CFG_IMAGE_WIDTH) begin
                r_width <= i_cfg_data;
            end else begin
                r_height <= i_cfg_data;
            end
        end
    end

    always_comb begin
        w_eff = r_width;
        if (r_width == '0) begin
            w_eff = gcf_pkg::CFG_W'(1);
        end else if (r_width > MAX_W) begin
            w_eff = MAX_W;
        end
        h_eff = r_height;
        if (r_height == '0) begin
            h_eff = gcf_pkg::CFG_W'(1);
        end else if (r_height > MAX_H) begin
            h_eff = MAX_H;
        end

        col_cur = {1'b0, r_col};
        row_tmp = {1'b0, r_row};
        if ({1'b0, r_col} >= w_eff) begin
            col_cur = '0;
            row_tmp = {1'b0, r_row} + 1'b1;
        end
        row_cur = (row_tmp >= h_eff) ? '0 : row_tmp;

        col_nxt = col_cur + 1'b1;
        row_nxt = row_cur;
        if (col_nxt >= w_eff) begin
            col_nxt = '0;
            row_nxt = row_cur + 1'b1;
            if (row_nxt >= h_eff) begin
                row_nxt = '0;
            end
        end

        new_right                    = (col_cur + 1'b1) < w_eff;
        new_mask[gcf_pkg::RES_UP]     = row_cur != '0;
        new_mask[gcf_pkg::RES_LEFT]   = (row_cur == h_eff - 1'b1) && (col_cur != '0);
        new_mask[gcf_pkg::RES_CORNER] = (row_cur == h_eff - 1'b1) && (col_cur == w_eff - 1'b1);
    end

    assign mask_rest     = r_mask & (r_mask - 1'b1);
    assign out_load      = !r_out_valid || m_axis_tready;
    assign emit          = (r_mask != '0) && out_load;
    assign s_axis_tready = (r_mask == '0) || (out_load && (mask_rest == '0));
    assign accept        = s_axis_tvalid && s_axis_tready;

    gcf_ram #(
        .WIDTH (gcf_pkg::PIX_W),
        .DEPTH (gcf_pkg::MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_we      (accept),
        .i_waddr   (col_cur[gcf_pkg::ADDR_W-1:0]),
        .i_wdata   (s_axis_tdata),
        .i_re      (accept),
        .i_raddr_a (col_cur[gcf_pkg::ADDR_W-1:0]),
        .i_raddr_b (col_cur[gcf_pkg::ADDR_W-1:0] + 1'b1),
        .o_rdata_a (above),
        .o_rdata_b (above_right)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_left <= '0;
            r_mask <= '0;
        end else if (accept) begin
            r_row  <= row_nxt[gcf_pkg::POS_W-1:0];
            r_col  <= col_nxt[gcf_pkg::POS_W-1:0];
            r_left <= s_axis_tdata;
            r_mask <= new_mask;
        end else if (emit) begin
            r_mask <= mask_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix   <= s_axis_tdata;
            r_s1_left  <= r_left;
            r_s1_row   <= row_cur[gcf_pkg::POS_W-1:0];
            r_s1_col   <= col_cur[gcf_pkg::POS_W-1:0];
            r_s1_right <= new_right;
        end
    end

    always_comb begin
        sel_row  = r_s1_row;
        sel_col  = r_s1_col;
        sel_done = 1'b0;
        if (r_mask[gcf_pkg::RES_UP]) begin
            sel_edge = {1'b0, gcf_pkg::abs_diff(above, r_s1_pix)}
                     + (r_s1_right ? {1'b0, gcf_pkg::abs_diff(above, above_right)}
                                   : '0);
            sel_row  = r_s1_row - 1'b1;
        end else if (r_mask[gcf_pkg::RES_LEFT]) begin
            sel_edge = {1'b0, gcf_pkg::abs_diff(r_s1_left, r_s1_pix)};
            sel_col  = r_s1_col - 1'b1;
        end else begin
            sel_edge = '0;
            sel_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_edge <= sel_edge;
            r_out_row  <= sel_row;
            r_out_col  <= sel_col;
            r_out_last <= mask_rest == '0;
            r_out_done <= sel_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = gcf_pkg::OUT_DATA_W'({r_out_col, r_out_row, r_out_edge});
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_done;

endmodule

[src/gcf_checker.sv]
module gcf_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [gcf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tlast,
    input logic                           m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled output word changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("image end word not last of its run");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[gcf_pkg::EDGE_W-1:0] == '0)
        else $error("corner word carries nonzero edge");

endmodule

bind gradient_contour_filter_unit gcf_checker u_gcf_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import gcf_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_ITEMS = 196;

    typedef logic [EDGE_W-1:0] t_edge;

    typedef struct packed {
        t_edge edge_val;
        t_pos  row;
        t_pos  col;
        logic  run_end;
        logic  frame_end;
    } grad_t;

    typedef enum logic {STEP_PIXEL, STEP_FRAME} step_kind_t;

    typedef struct packed {
        step_kind_t       kind;
        t_pixel           px;
        t_dim             w;
        t_dim             h;
        logic             typed;
        logic [0:2][EDGE_W-1:0] grads;
    } step_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic                  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata;   // pixel_value
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // edge_value, out_row, out_col
    logic                  m_axis_tlast;   // last_of_run
    logic                  m_axis_tuser;   // image_done

    gradient_contour_filter_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predictor state
    t_pixel line_mem [MAX_WIDTH];
    t_pixel left_px;
    t_pos   row_pos;
    t_pos   col_pos;
    t_dim   img_w;
    t_dim   img_h;

    grad_t  pending_grads [$];
    grad_t  want_grad;
    int     errors;
    int     cycles;
    int     burst_left;
    t_pixel prev_px;
    int     random_items;
    int     frame_w;
    int     frame_h;

    logic [15:0] ready_mask = 16'hFFFF;
    int          mask_left  = 0;
    logic [3:0]  mask_phase = '0;

    step_t script [23] = '{
        '{STEP_PIXEL, 16'hFFFF, 10'd0,    10'd0,    1'b1, '{17'd0,      17'd0,     17'd0}},
        '{STEP_PIXEL, 16'h0000, 10'd0,    10'd0,    1'b1, '{17'd0,      17'd0,     17'd0}},
        '{STEP_PIXEL, 16'hFFFF, 10'd0,    10'd0,    1'b1, '{17'd0,      17'd0,     17'd0}},
        '{STEP_FRAME, 16'h0000, 10'd3,    10'd2,    1'b0, '{17'd0,      17'd0,     17'd0}},
        '{STEP_PIXEL, 16'h0000, 10'd0,    10'd0,    1'b1, '{17'h1FFFE,  17'd0,     17'd0}},
        '{STEP_PIXEL, 16'hFFFF, 10'd0,    10'd0,    1'b1, '{17'h1FFFE,  17'hFFFF,  17'd0}},
        '{STEP_PIXEL, 16'h0000, 10'd0,    10'd0,    1'b1, '{17'hFFFF,   17'hFFFF,  17'd0}},
        '{STEP_FRAME, 16'h0000, 10'd4,    10'd1,    1'b0, '{17'd0,      17'd0,     17'd0}},
        '{STEP_PIXEL, 16'h0000, 10'd0,    10'd0,    1'b1, '{17'd0,      17'd0,     17'd0}},
        '{STEP_PIXEL, 16'h0005, 10'd0,    10'd0,    1'b1, '{17'd5,      17'd0,     17'd0}},
        '{STEP_PIXEL, 16'h0003, 10'd0,    10'd0,    1'b1, '{17'd2,      17'd0,     17'd0}},
        '{STEP_PIXEL, 16'h0003, 10'd0,    10'd0,    1'b1, '{17'd0,      17'd0,     17'd0}},
        '{STEP_FRAME, 16'h0000, 10'd1,    10'd3,    1'b0, '{17'd0,      17'd0,     17'd0}},
        '{STEP_PIXEL, 16'h0007, 10'd0,    10'd0,    1'b1, '{17'd0,      17'd0,     17'd0}},
        '{STEP_PIXEL, 16'h0002, 10'd0,    10'd0,    1'b1, '{17'd5,      17'd0,     17'd0}},
        '{STEP_PIXEL, 16'h0009, 10'd0,    10'd0,    1'b1, '{17'd7,      17'd0,     17'd0}},
        '{STEP_FRAME, 16'h0000, 10'd0,    10'd0,    1'b0, '{17'd0,      17'd0,     17'd0}},
        '{STEP_PIXEL, 16'hABCD, 10'd0,    10'd0,    1'b1, '{17'd0,      17'd0,     17'd0}},
        '{STEP_FRAME, 16'h0000, 10'd2,    10'd2,    1'b0, '{17'd0,      17'd0,     17'd0}},
        '{STEP_PIXEL, 16'h1234, 10'd0,    10'd0,    1'b0, '{17'd0,      17'd0,     17'd0}},
        '{STEP_PIXEL, 16'h8000, 10'd0,    10'd0,    1'b0, '{17'd0,      17'd0,     17'd0}},
        '{STEP_PIXEL, 16'h7FFF, 10'd0,    10'd0,    1'b0, '{17'd0,      17'd0,     17'd0}},
        '{STEP_PIXEL, 16'h0001, 10'd0,    10'd0,    1'b0, '{17'd0,      17'd0,     17'd0}}
    };

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_edge pix_gap(input t_pixel a, input t_pixel b);
        return (a > b) ? t_edge'(a - b) : t_edge'(b - a);
    endfunction

    function automatic int clamp_dim(input t_dim d, input int top);
        if (d == '0)
            return 1;
        return (int'(d) > top) ? top : int'(d);
    endfunction

    function automatic void compute_gradients(input t_pixel px, input logic typed,
                                              input logic [0:2][EDGE_W-1:0] typed_grads);
        int     w;
        int     h;
        int     r;
        int     c;
        int     n;
        t_edge  e;
        t_pixel above;
        grad_t  found [3];
        w = clamp_dim(img_w, MAX_WIDTH);
        h = clamp_dim(img_h, MAX_HEIGHT);
        r = int'(row_pos);
        c = int'(col_pos);
        n = 0;
        if (c >= w) begin
            c = 0;
            r++;
        end
        if (r >= h)
            r = 0;
        if (r >= 1) begin
            above = line_mem[c];
            e = pix_gap(above, px);
            if (c + 1 < w)
                e = e + pix_gap(above, line_mem[c+1]);
            found[n] = '{e, t_pos'(r - 1), t_pos'(c), 1'b0, 1'b0};
            n++;
        end
        if (r == h - 1) begin
            if (c >= 1) begin
                found[n] = '{pix_gap(left_px, px), t_pos'(r), t_pos'(c - 1), 1'b0, 1'b0};
                n++;
            end
            if (c == w - 1) begin
                found[n] = '{t_edge'(0), t_pos'(r), t_pos'(c), 1'b0, 1'b1};
                n++;
            end
        end
        line_mem[c] = px;
        left_px = px;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        col_pos = t_pos'(c);
        row_pos = t_pos'(r);
        for (int i = 0; i < n; i++) begin
            if (i == n - 1)
                found[i].run_end = 1'b1;
            if (typed)
                found[i].edge_val = typed_grads[i];
            pending_grads.push_back(found[i]);
        end
    endfunction

    function automatic t_pixel pick_pixel();
        case ($urandom_range(0, 7))
            0: prev_px = '0;
            1: prev_px = '1;
            2, 3: prev_px = prev_px ^ t_pixel'($urandom_range(0, 15));
            default: prev_px = t_pixel'($urandom);
        endcase
        return prev_px;
    endfunction

    task automatic send_pixel(input t_pixel px, input logic typed,
                              input logic [0:2][EDGE_W-1:0] typed_grads);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_axis_tdata  <= px;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        compute_gradients(px, typed, typed_grads);
        @(negedge i_clk);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_grads.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_frame(input t_dim w, input t_dim h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_IMAGE_WIDTH;
        i_cfg_data  <= w;
        @(negedge i_clk);
        i_cfg_index <= CFG_IMAGE_HEIGHT;
        i_cfg_data  <= h;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        img_w = w;
        img_h = h;
    endtask

    task automatic send_image(input t_dim w, input t_dim h, inout int sent);
        int total;
        settle();
        set_frame(w, h);
        total = clamp_dim(w, MAX_WIDTH) * clamp_dim(h, MAX_HEIGHT);
        for (int i = 0; i < total; i++)
            send_pixel(pick_pixel(), 1'b0, '0);
        sent += total;
    endtask

    always @(negedge i_clk) begin
        if (mask_left == 0) begin
            ready_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                      : (16'($urandom) | 16'h0001);
            mask_left  <= $urandom_range(20, 100);
        end else begin
            mask_left <= mask_left - 1;
        end
        m_axis_tready <= ready_mask[mask_phase];
        mask_phase    <= mask_phase + 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_grads.size() == 0) begin
                $error("unexpected result word: tdata=%h", m_axis_tdata);
                errors++;
            end else begin
                want_grad = pending_grads.pop_front();
                if (m_axis_tdata[EDGE_W-1:0] !== want_grad.edge_val) begin
                    $error("edge_value: expected %0d, got %0d",
                           want_grad.edge_val, m_axis_tdata[EDGE_W-1:0]);
                    errors++;
                end
                if (m_axis_tdata[EDGE_W +: POS_W] !== want_grad.row) begin
                    $error("out_row: expected %0d, got %0d",
                           want_grad.row, m_axis_tdata[EDGE_W +: POS_W]);
                    errors++;
                end
                if (m_axis_tdata[EDGE_W+POS_W +: POS_W] !== want_grad.col) begin
                    $error("out_col: expected %0d, got %0d",
                           want_grad.col, m_axis_tdata[EDGE_W+POS_W +: POS_W]);
                    errors++;
                end
                if (m_axis_tlast !== want_grad.run_end) begin
                    $error("last_of_run: expected %0d, got %0d",
                           want_grad.run_end, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tuser !== want_grad.frame_end) begin
                    $error("image_done: expected %0d, got %0d",
                           want_grad.frame_end, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_IMAGE_WIDTH;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        errors        = 0;
        cycles        = 0;
        burst_left    = 0;
        prev_px       = '0;
        random_items  = 0;
        left_px       = '0;
        row_pos       = '0;
        col_pos       = '0;
        img_w         = t_dim'(MAX_WIDTH);
        img_h         = t_dim'(MAX_HEIGHT);
        foreach (line_mem[i])
            line_mem[i] = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[i]) begin
            if (script[i].kind == STEP_FRAME) begin
                settle();
                set_frame(script[i].w, script[i].h);
            end else begin
                send_pixel(script[i].px, script[i].typed, script[i].grads);
            end
        end

        while (random_items < RANDOM_ITEMS) begin
            frame_w = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 9);
            frame_h = $urandom_range(1, 6);
            send_image(t_dim'(frame_w), t_dim'(frame_h), random_items);
        end

        settle();
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
